// ===== rtl/core/skc_pkg.sv =====
// Shared types, constants and table functions of the stereo soft-knee compressor.
package skc_pkg;

	typedef enum logic [4:0] {
		S_IDLE, S_DET, S_PW1, S_PW2, S_PW3, S_PW4,
		S_LNK1, S_LNK2, S_LNK3, S_NRM0, S_NRM,
		S_LOG1, S_LOG2, S_LOG3, S_LOG4,
		S_CRV, S_CRV_SQ, S_CRV_DIV, S_CRV_LIN,
		S_ENV1, S_ENV2, S_ENV3,
		S_GN0, S_GN1, S_GN2, S_GN3,
		S_APP, S_APP2, S_MIX1, S_MIX2, S_MIX3, S_OUT
	} seq_state_t;

	typedef enum logic [3:0] {
		REG_THRESHOLD = 4'd0,
		REG_SLOPE     = 4'd1,
		REG_KNEE      = 4'd2,
		REG_ATTACK    = 4'd3,
		REG_RELEASE   = 4'd4,
		REG_WET       = 4'd5,
		REG_DRY       = 4'd6,
		REG_CONTROL   = 4'd7
	} cfg_reg_t;

	typedef enum logic [1:0] {
		DET_MAX   = 2'd0,
		DET_AVG   = 2'd1,
		DET_POWER = 2'd2
	} det_mode_t;

	typedef enum logic {
		DU_DIV  = 1'b0,
		DU_SQRT = 1'b1
	} du_op_t;

	typedef struct packed {
		logic   start;
		du_op_t op;
	} du_req_t;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 17;
	localparam int MUL_W      = 33;
	localparam int PROD_W     = 66;

	localparam logic [30:0] DB_PER_LOG2_Q28 = 31'd1616142483;
	localparam logic [29:0] LOG2_PER_DB_Q32 = 30'd713378626;
	localparam logic [30:0] ONE_Q30         = 31'h4000_0000;

	localparam logic [15:0] RST_THRESHOLD = 16'hEC00;
	localparam logic [16:0] RST_SLOPE     = 17'd32768;
	localparam logic [13:0] RST_KNEE      = 14'd1536;
	localparam logic [15:0] RST_ATTACK    = 16'd64880;
	localparam logic [15:0] RST_RELEASE   = 16'd65500;
	localparam logic [15:0] RST_WET       = 16'd4096;
	localparam logic [16:0] RST_DRY       = 17'd0;
	localparam logic [11:0] RST_CONTROL   = 12'd0;

	function automatic logic [24:0] log2_frac(input int unsigned i, input int unsigned ib);
		longint unsigned v;
		logic [24:0] y;
		if (i >= (32'd1 << ib)) begin
			return 25'h100_0000;
		end
		v = (64'd1 << 30) + (64'(i) << (30 - ib));
		y = '0;
		for (int b = 1; b <= 24; b++) begin
			v = (v * v) >> 30;
			if (v >= (64'd1 << 31)) begin
				v = v >> 1;
				y[24 - b] = 1'b1;
			end
		end
		return y;
	endfunction

	function automatic longint unsigned isqrt64(input longint unsigned n);
		longint unsigned res;
		longint unsigned bt;
		longint unsigned rem;
		res = 0;
		bt = 64'd1 << 62;
		rem = n;
		for (int j = 0; j < 32; j++) begin
			if (rem >= res + bt) begin
				rem = rem - (res + bt);
				res = (res >> 1) + bt;
			end else begin
				res = res >> 1;
			end
			bt = bt >> 2;
		end
		return res;
	endfunction

	function automatic logic [30:0] root_val(input int unsigned i);
		longint unsigned r;
		r = 64'd1 << 29;
		for (int j = 1; j <= 24; j++) begin
			if (j <= i) begin
				r = isqrt64(r << 30);
			end
		end
		return 31'(r);
	endfunction

endpackage

// ===== rtl/core/skc_mul.sv =====
// Shared signed multiplier with a registered product.
module skc_mul (
	input  logic                              clk,
	input  logic signed [skc_pkg::MUL_W-1:0]  a,
	input  logic signed [skc_pkg::MUL_W-1:0]  b,
	output logic signed [skc_pkg::PROD_W-1:0] p
);
	import skc_pkg::*;

	always_ff @(posedge clk) begin
		p <= a * b;
	end

endmodule

// ===== rtl/core/skc_divsqrt.sv =====
// Iterative restoring divider and integer square root, one result bit per cycle.
module skc_divsqrt (
	input  logic             clk,
	input  logic             arst_n,
	input  skc_pkg::du_req_t req,
	input  logic [63:0]      num,
	input  logic [30:0]      den,
	output logic             done,
	output logic [31:0]      res
);
	import skc_pkg::*;

	logic        run_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	du_op_t      op_q;
	logic [63:0] acc_q;
	logic [63:0] res_q;
	logic [63:0] bit_q;
	logic [63:0] cand;
	logic        ge;

	assign cand = (op_q == DU_SQRT) ? res_q + bit_q : bit_q;
	assign ge   = acc_q >= cand;
	assign done = done_q;
	assign res  = res_q[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= DU_DIV;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= 6'd32;
				op_q  <= req.op;
			end else if (run_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= num;
			res_q <= '0;
			bit_q <= (req.op == DU_SQRT) ? 64'h4000_0000_0000_0000 : {2'b00, den, 31'd0};
		end else if (run_q) begin
			acc_q <= ge ? acc_q - cand : acc_q;
			if (op_q == DU_SQRT) begin
				res_q <= ge ? (res_q >> 1) + bit_q : res_q >> 1;
				bit_q <= bit_q >> 2;
			end else begin
				res_q <= {res_q[62:0], ge};
				bit_q <= bit_q >> 1;
			end
		end
	end

endmodule

// ===== rtl/core/stereo_soft_knee_compressor.sv =====
// Top level of the stereo soft-knee compressor with its sequencer and datapath.
// Each stereo word passes through the sequencer from acceptance to its result:
// each channel forms its linear gain in the shared multiplier from the smoothed
// reduction, the soft-knee region adds a divide per channel in the divide/root
// unit over the linear region, and power detection adds one square root in that
// unit at the start. The block takes one word at a time and raises s_tready again
// once the result has moved into the output register, which waits there while
// m_tready is low.
module stereo_soft_knee_compressor #(
	parameter int SAMPLE_BITS       = 24,
	parameter int LOG_TABLE_ENTRIES = 256,
	localparam int S_W = ((2 * SAMPLE_BITS + 7) / 8) * 8,
	localparam int M_W = ((2 * SAMPLE_BITS + 16 + 7) / 8) * 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [S_W-1:0]                     s_tdata,  // left_in, right_in
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [M_W-1:0]                     m_tdata,  // left_out, right_out, reduction_db
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [skc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [skc_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import skc_pkg::*;

	localparam int SB    = SAMPLE_BITS;
	localparam int FB    = SB - 1;
	localparam int IB    = $clog2(LOG_TABLE_ENTRIES);
	localparam int SH    = 30 - IB;
	localparam int TAB_N = (1 << IB) + 1;
	localparam logic signed [PROD_W-1:0] SMP_HI = (PROD_W'(1) <<< FB) - PROD_W'(1);
	localparam logic signed [PROD_W-1:0] SMP_LO = -(PROD_W'(1) <<< FB);

	function automatic logic [SB-1:0] mag_of(input logic signed [SB-1:0] v);
		return v[SB-1] ? SB'(-v) : SB'(v);
	endfunction

	// Configuration registers.
	logic signed [15:0] thr_q;
	logic [16:0]        slope_q;
	logic [13:0]        knee_q;
	logic [15:0]        att_q;
	logic [15:0]        rel_q;
	logic [15:0]        wet_q;
	logic [16:0]        dry_q;
	logic [11:0]        ctrl_q;

	det_mode_t det_mode;
	logic      fbk;
	logic      mono;
	logic [7:0] link;

	assign det_mode  = det_mode_t'(ctrl_q[1:0]);
	assign fbk       = ctrl_q[2];
	assign mono      = ctrl_q[3];
	assign link      = ctrl_q[11:4];
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q   <= RST_THRESHOLD;
			slope_q <= RST_SLOPE;
			knee_q  <= RST_KNEE;
			att_q   <= RST_ATTACK;
			rel_q   <= RST_RELEASE;
			wet_q   <= RST_WET;
			dry_q   <= RST_DRY;
			ctrl_q  <= RST_CONTROL;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_THRESHOLD: thr_q   <= cfg_data[15:0];
				REG_SLOPE:     slope_q <= cfg_data[16:0];
				REG_KNEE:      knee_q  <= cfg_data[13:0];
				REG_ATTACK:    att_q   <= cfg_data[15:0];
				REG_RELEASE:   rel_q   <= cfg_data[15:0];
				REG_WET:       wet_q   <= cfg_data[15:0];
				REG_DRY:       dry_q   <= cfg_data[16:0];
				REG_CONTROL:   ctrl_q  <= cfg_data[11:0];
				default: begin
				end
			endcase
		end
	end

	// Constant tables.
	logic [24:0] log_tab [TAB_N];
	logic [30:0] root_tab [25];

	for (genvar gi = 0; gi < TAB_N; gi++) begin : g_log
		assign log_tab[gi] = log2_frac(gi, IB);
	end
	for (genvar gr = 0; gr < 25; gr++) begin : g_root
		assign root_tab[gr] = root_val(gr);
	end

	// Sequencer and datapath registers.
	seq_state_t state_q;
	seq_state_t state_d;
	logic       ch_q;
	logic [4:0] cnt_q;

	logic signed [SB-1:0] l_q;
	logic signed [SB-1:0] r_q;
	logic [SB-1:0]        rl_q;
	logic [SB-1:0]        rr_q;
	logic [SB-1:0]        det_q;
	logic [SB-1:0]        lvl_q;
	logic [31:0]          nrm_q;
	logic [4:0]           k_q;
	logic [24:0]          tab0_q;
	logic signed [63:0]   acc_q;
	logic [30:0]          x_q;
	logic [15:0]          coef_q;
	logic [28:0]          y_q;
	logic [30:0]          gain_q;
	logic [30:0]          env_q [2];
	logic signed [SB-1:0] fb_q [2];
	logic signed [SB-1:0] mix_q [2];
	logic signed [SB-1:0] out_q [2];
	logic [15:0]          red_q;
	logic                 m_tvalid_q;

	logic signed [MUL_W-1:0]  mul_a;
	logic signed [MUL_W-1:0]  mul_b;
	logic signed [PROD_W-1:0] p_q;
	du_req_t                  du_req;
	logic [63:0]              du_num;
	logic [30:0]              du_den;
	logic                     du_done;
	logic [31:0]              du_res;
	logic [IB:0]              tab_addr;
	logic [24:0]              tab_rd;

	skc_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (p_q)
	);

	skc_divsqrt u_du (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (du_req),
		.num    (du_num),
		.den    (du_den),
		.done   (du_done),
		.res    (du_res)
	);

	// Combinational helpers.
	logic signed [SB-1:0]     in_l;
	logic signed [SB-1:0]     in_r;
	logic signed [SB-1:0]     src_l;
	logic signed [SB-1:0]     src_r;
	logic [SB-1:0]            mag_ch;
	logic signed [SB-1:0]     smp_ch;
	logic signed [PROD_W-1:0] acc_sum;
	logic signed [PROD_W-1:0] mix_v;
	logic [5:0]               nrm_sh;
	logic [31:0]              nrm_mask;
	logic [SH-1:0]            lg_rem;
	logic [24:0]              lg_frac;
	logic [29:0]              lg_a2;
	logic                     lg_silent;
	logic signed [63:0]       crv_kh;
	logic signed [63:0]       crv_s;
	logic [30:0]              env_t;
	logic [SB-1:0]            app_pm;
	logic [30:0]              gn_g;

	assign in_l     = s_tdata[SB-1:0];
	assign in_r     = s_tdata[2*SB-1:SB];
	assign src_l    = fbk ? fb_q[0] : in_l;
	assign src_r    = fbk ? fb_q[1] : (mono ? '0 : in_r);
	assign mag_ch   = (ch_q && !mono) ? rr_q : rl_q;
	assign smp_ch   = ch_q ? r_q : l_q;
	assign acc_sum  = PROD_W'(acc_q) + p_q;
	assign mix_v    = acc_sum >>> 16;
	assign nrm_sh   = 6'd1 << cnt_q;
	assign nrm_mask = ~(32'hFFFF_FFFF >> nrm_sh);
	assign lg_rem   = nrm_q[30-IB:1];
	assign lg_frac  = tab0_q + 25'(p_q >>> SH);
	assign lg_a2    = 30'((30'(FB) - 30'(k_q)) << 24) - 30'(lg_frac);
	assign lg_silent = {27'd0, k_q} >= 32'(FB);
	assign crv_kh   = {35'd0, knee_q, 15'd0};
	assign crv_s    = acc_q + crv_kh;
	assign env_t    = env_q[ch_q];
	assign app_pm   = SB'(p_q >>> 30);
	assign gn_g     = p_q[60:30];
	assign tab_rd   = log_tab[tab_addr];
	assign du_den   = {knee_q, 17'd0};

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:    if (s_tvalid) state_d = S_DET;
			S_DET:     state_d = (det_mode == DET_POWER) ? S_PW1 : S_LNK1;
			S_PW1:     state_d = S_PW2;
			S_PW2:     state_d = S_PW3;
			S_PW3:     state_d = S_PW4;
			S_PW4:     if (du_done) state_d = S_LNK1;
			S_LNK1:    state_d = mono ? S_NRM0 : S_LNK2;
			S_LNK2:    state_d = S_LNK3;
			S_LNK3:    state_d = S_NRM0;
			S_NRM0:    state_d = S_NRM;
			S_NRM:     if (cnt_q == 5'd0) state_d = S_LOG1;
			S_LOG1:    state_d = S_LOG2;
			S_LOG2:    state_d = S_LOG3;
			S_LOG3:    state_d = lg_silent ? S_CRV : S_LOG4;
			S_LOG4:    state_d = S_CRV;
			S_CRV: begin
				if (acc_q <= -crv_kh) begin
					state_d = S_ENV1;
				end else if (acc_q < crv_kh) begin
					state_d = S_CRV_SQ;
				end else begin
					state_d = S_CRV_LIN;
				end
			end
			S_CRV_SQ:  state_d = S_CRV_DIV;
			S_CRV_DIV: if (du_done) state_d = S_CRV_LIN;
			S_CRV_LIN: state_d = S_ENV1;
			S_ENV1:    state_d = S_ENV2;
			S_ENV2:    state_d = S_ENV3;
			S_ENV3:    state_d = S_GN0;
			S_GN0:     state_d = S_GN1;
			S_GN1:     state_d = S_GN2;
			S_GN2:     if (cnt_q == 5'd24) state_d = S_GN3;
			S_GN3:     state_d = S_APP;
			S_APP:     state_d = S_APP2;
			S_APP2:    state_d = S_MIX1;
			S_MIX1:    state_d = S_MIX2;
			S_MIX2:    state_d = S_MIX3;
			S_MIX3:    state_d = ch_q ? S_OUT : S_LNK1;
			S_OUT:     if (!m_tvalid_q || m_tready) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	// Sequencer outputs: handshake, multiplier operands, unit requests, table address.
	always_comb begin
		s_tready = 1'b0;
		mul_a    = '0;
		mul_b    = '0;
		du_req   = '{start: 1'b0, op: DU_DIV};
		du_num   = '0;
		tab_addr = {1'b0, nrm_q[30 -: IB]};
		unique case (state_q)
			S_IDLE: s_tready = 1'b1;
			S_PW1: begin
				mul_a = MUL_W'(rl_q);
				mul_b = MUL_W'(rl_q);
			end
			S_PW2: begin
				mul_a = MUL_W'(rr_q);
				mul_b = MUL_W'(rr_q);
			end
			S_PW3: begin
				du_req = '{start: 1'b1, op: DU_SQRT};
				du_num = 64'(acc_sum >>> 1);
			end
			S_LNK1: begin
				mul_a = MUL_W'(mag_ch);
				mul_b = MUL_W'(9'd256 - 9'(link));
			end
			S_LNK2: begin
				mul_a = MUL_W'(det_q);
				mul_b = MUL_W'(link);
			end
			S_LOG2: begin
				tab_addr = {1'b0, nrm_q[30 -: IB]} + 1'b1;
				mul_a    = MUL_W'(tab_rd - tab0_q);
				mul_b    = MUL_W'(lg_rem);
			end
			S_LOG3: begin
				mul_a = MUL_W'(lg_a2);
				mul_b = MUL_W'(DB_PER_LOG2_Q28);
			end
			S_CRV: begin
				if (acc_q < crv_kh) begin
					mul_a = MUL_W'(crv_s[29:0]);
					mul_b = MUL_W'(crv_s[29:0]);
				end else begin
					mul_a = MUL_W'(acc_q[31:0]);
					mul_b = MUL_W'(slope_q);
				end
			end
			S_CRV_SQ: begin
				du_req = '{start: 1'b1, op: DU_DIV};
				du_num = 64'(p_q);
			end
			S_CRV_DIV: begin
				mul_a = MUL_W'(du_res);
				mul_b = MUL_W'(slope_q);
			end
			S_ENV1: begin
				mul_a = MUL_W'((x_q > env_t) ? att_q : rel_q);
				mul_b = MUL_W'(env_t);
			end
			S_ENV2: begin
				mul_a = MUL_W'(17'h1_0000 - 17'(coef_q));
				mul_b = MUL_W'(x_q);
			end
			S_GN0: begin
				mul_a = MUL_W'(env_t);
				mul_b = MUL_W'(LOG2_PER_DB_Q32);
			end
			S_GN2: begin
				mul_a = (cnt_q == 5'd1) ? MUL_W'(ONE_Q30) : MUL_W'(gn_g);
				mul_b = y_q[5'd24 - cnt_q] ? MUL_W'(root_tab[cnt_q]) : MUL_W'(ONE_Q30);
			end
			S_APP: begin
				mul_a = MUL_W'(mag_of(smp_ch));
				mul_b = MUL_W'(gain_q);
			end
			S_MIX1: begin
				mul_a = MUL_W'(fb_q[ch_q]);
				mul_b = MUL_W'(wet_q);
			end
			S_MIX2: begin
				mul_a = MUL_W'(smp_ch);
				mul_b = MUL_W'(dry_q);
			end
			default: begin
			end
		endcase
	end

	// Control registers and channel state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			ch_q       <= 1'b0;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
			env_q[0]   <= '0;
			env_q[1]   <= '0;
			fb_q[0]    <= '0;
			fb_q[1]    <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_OUT && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_DET:  ch_q <= 1'b0;
				S_NRM0: cnt_q <= 5'd4;
				S_NRM:  if (cnt_q != 5'd0) cnt_q <= cnt_q - 5'd1;
				S_ENV3: env_q[ch_q] <= 31'(acc_sum >>> 16);
				S_GN1:  cnt_q <= 5'd1;
				S_GN2:  if (cnt_q != 5'd24) cnt_q <= cnt_q + 5'd1;
				S_APP2: begin
					if (ch_q && mono) begin
						fb_q[ch_q] <= '0;
					end else begin
						fb_q[ch_q] <= smp_ch[SB-1] ? SB'(-app_pm) : SB'(app_pm);
					end
				end
				S_MIX3: if (!ch_q) ch_q <= 1'b1;
				default: begin
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					l_q  <= in_l;
					r_q  <= mono ? '0 : in_r;
					rl_q <= mag_of(src_l);
					rr_q <= mag_of(src_r);
				end
			end
			S_DET: begin
				case (det_mode)
					DET_AVG: det_q <= SB'(({1'b0, rl_q} + {1'b0, rr_q}) >> 1);
					default: det_q <= (rl_q > rr_q) ? rl_q : rr_q;
				endcase
			end
			S_PW2:  acc_q <= 64'(p_q);
			S_PW4:  if (du_done) det_q <= SB'(du_res);
			S_LNK1: if (mono) lvl_q <= rl_q;
			S_LNK2: acc_q <= 64'(p_q);
			S_LNK3: lvl_q <= SB'(acc_sum >>> 8);
			S_NRM0: begin
				nrm_q <= (lvl_q == '0) ? 32'd1 : 32'(lvl_q);
				k_q   <= 5'd31;
			end
			S_NRM: begin
				if ((nrm_q & nrm_mask) == 32'd0) begin
					nrm_q <= nrm_q << nrm_sh;
					k_q   <= k_q - 5'(nrm_sh);
				end
			end
			S_LOG1: tab0_q <= tab_rd;
			S_LOG3: if (lg_silent) acc_q <= -(64'(thr_q) <<< 16);
			S_LOG4: acc_q <= -64'(p_q >>> 28) - (64'(thr_q) <<< 16);
			S_CRV:  if (acc_q <= -crv_kh) x_q <= '0;
			S_CRV_LIN: begin
				if (p_q[PROD_W-1:47] != '0) begin
					x_q <= 31'h7FFF_FFFF;
				end else begin
					x_q <= p_q[46:16];
				end
			end
			S_ENV1: coef_q <= (x_q > env_t) ? att_q : rel_q;
			S_ENV2: acc_q <= 64'(p_q);
			S_GN1:  y_q <= 29'(p_q >>> 32);
			S_GN3:  gain_q <= (y_q[28:24] == 5'd31) ? '0 : gn_g >> y_q[28:24];
			S_MIX2: acc_q <= 64'(p_q) <<< 4;
			S_MIX3: begin
				if (ch_q && mono) begin
					mix_q[ch_q] <= '0;
				end else if (mix_v > SMP_HI) begin
					mix_q[ch_q] <= SB'(SMP_HI);
				end else if (mix_v < SMP_LO) begin
					mix_q[ch_q] <= SB'(SMP_LO);
				end else begin
					mix_q[ch_q] <= SB'(mix_v);
				end
			end
			S_OUT: begin
				if (!m_tvalid_q || m_tready) begin
					out_q[0] <= mix_q[0];
					out_q[1] <= mix_q[1];
					red_q <= (env_q[0] > env_q[1]) ? env_q[0][30:15] >> 1 : env_q[1][30:15] >> 1;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = M_W'({red_q, out_q[1], out_q[0]});

endmodule

// ===== rtl/core/skc_checker.sv =====
// Port-level checks of the stereo soft-knee compressor and their binding.
module skc_checker #(
	parameter int M_W = 64
) (
	input logic           clk,
	input logic           arst_n,
	input logic           s_tvalid,
	input logic           s_tready,
	input logic           m_tvalid,
	input logic           m_tready,
	input logic [M_W-1:0] m_tdata
);

	// A word is worked on alone, so input is closed right after acceptance.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input still open after a word was accepted");

	// A new result is only produced while no input word can be taken.
	a_result_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result appeared while input was open");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled output word changed");

endmodule

bind stereo_soft_knee_compressor skc_checker #(.M_W(M_W)) u_skc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== bench/testbench.sv =====
// Testbench for the stereo soft-knee compressor: random and directed words checked by a predictor.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import skc_pkg::*;

	typedef longint unsigned u64;
	typedef longint s64;

	typedef struct {
		logic [23:0] left;
		logic [23:0] right;
		logic [15:0] reduction;
	} gained_word_t;

	localparam int CYCLE_LIMIT = 2000000;

	class gain_scoreboard;
		s64 thr;
		u64 slope, knee, atk, rel, wet, dry, ctrl;
		u64 env_l, env_r;
		s64 fb_l, fb_r;
		u64 log_seg[257];
		u64 root2[25];
		gained_word_t pending[$];
		int errors;

		function u64 int_sqrt(u64 n);
			u64 res, bt;
			res = 0;
			bt = u64'(1) << 62;
			while (bt > n) bt = bt >> 2;
			while (bt != 0) begin
				if (n >= res + bt) begin
					n = n - (res + bt);
					res = (res >> 1) + bt;
				end else begin
					res = res >> 1;
				end
				bt = bt >> 2;
			end
			return res;
		endfunction

		function new();
			u64 v, y;
			for (int i = 0; i < 256; i++) begin
				v = (u64'(1) << 30) + (u64'(i) << 22);
				y = 0;
				for (int b = 1; b <= 24; b++) begin
					v = (v * v) >> 30;
					if (v >= (u64'(1) << 31)) begin
						v = v >> 1;
						y = y | (u64'(1) << (24 - b));
					end
				end
				log_seg[i] = y;
			end
			log_seg[256] = u64'(1) << 24;
			root2[0] = u64'(1) << 29;
			for (int i = 1; i <= 24; i++) root2[i] = int_sqrt(root2[i-1] << 30);
			thr = -5120;
			slope = 32768;
			knee = 1536;
			atk = 64880;
			rel = 65500;
			wet = 4096;
			dry = 0;
			ctrl = 0;
			env_l = 0;
			env_r = 0;
			fb_l = 0;
			fb_r = 0;
			errors = 0;
		endfunction

		function void write_reg(logic [3:0] idx, logic [16:0] data);
			case (idx)
				REG_THRESHOLD: thr = s64'($signed(data[15:0]));
				REG_SLOPE:     slope = u64'(data);
				REG_KNEE:      knee = u64'(data[13:0]);
				REG_ATTACK:    atk = u64'(data[15:0]);
				REG_RELEASE:   rel = u64'(data[15:0]);
				REG_WET:       wet = u64'(data[15:0]);
				REG_DRY:       dry = u64'(data);
				REG_CONTROL:   ctrl = u64'(data[11:0]);
				default: ;
			endcase
		endfunction

		function u64 atten_db(u64 mag);
			int k;
			u64 mant, t, idx, rem, frac;
			if (mag == 0) mag = 1;
			k = 0;
			while (k < 63 && (mag >> (k + 1)) != 0) k++;
			mant = k <= 30 ? (mag << (30 - k)) : (mag >> (k - 30));
			t = mant - (u64'(1) << 30);
			idx = t >> 22;
			rem = t & ((u64'(1) << 22) - 1);
			frac = log_seg[idx] + (((log_seg[idx+1] - log_seg[idx]) * rem) >> 22);
			if (k >= 23) return 0;
			return (((u64'(23 - k) << 24) - frac) * 64'd1616142483) >> 28;
		endfunction

		function u64 curve_of(u64 mag);
			s64 over, kn, kh;
			u64 s, r;
			over = -s64'(atten_db(mag)) - thr * 65536;
			kn = s64'(knee << 16);
			kh = kn / 2;
			if (over <= -kh) return 0;
			if (over < kh) begin
				s = u64'(over + kh);
				r = (((s * s) / u64'(2 * kn)) * slope) >> 16;
			end else begin
				r = (u64'(over) * slope) >> 16;
			end
			return r > 64'h7FFF_FFFF ? 64'h7FFF_FFFF : r;
		endfunction

		function u64 smooth(u64 x, u64 t);
			u64 a;
			a = x > t ? atk : rel;
			return ((a * t + (65536 - a) * x) >> 16) & 64'hFFFF_FFFF;
		endfunction

		function u64 lin_gain(u64 env);
			u64 y, n, g;
			y = (env * 64'd713378626) >> 32;
			n = y >> 24;
			g = u64'(1) << 30;
			for (int k = 1; k <= 24; k++)
				if (y[24-k]) g = (g * root2[k]) >> 30;
			return n >= 31 ? 0 : g >> n;
		endfunction

		function s64 scale(s64 s, u64 g);
			u64 m;
			s64 p;
			m = s < 0 ? u64'(-s) : u64'(s);
			p = s64'((m * g) >> 30);
			return s < 0 ? -p : p;
		endfunction

		function s64 mix(s64 fb, s64 d);
			s64 acc, v;
			acc = fb * s64'(wet) * 16 + d * s64'(dry);
			v = acc >>> 16;
			if (v > 8388607) return 8388607;
			if (v < -8388608) return -8388608;
			return v;
		endfunction

		function void note_input(logic [23:0] li, logic [23:0] ri);
			bit mono, fbk;
			u64 mode, link, rl, rr, det, lnl, lnr;
			s64 l, r, sl, sr;
			gained_word_t w;
			mono = ctrl[3];
			fbk = ctrl[2];
			mode = ctrl & 3;
			link = (ctrl >> 4) & 255;
			l = s64'($signed(li));
			r = mono ? 0 : s64'($signed(ri));
			sl = fbk ? fb_l : l;
			sr = fbk ? fb_r : r;
			rl = sl < 0 ? u64'(-sl) : u64'(sl);
			rr = sr < 0 ? u64'(-sr) : u64'(sr);
			if (mode == DET_AVG) det = (rl + rr) >> 1;
			else if (mode == DET_POWER) det = int_sqrt((rl * rl + rr * rr) >> 1);
			else det = rl > rr ? rl : rr;
			if (mono) begin
				lnl = rl;
				lnr = rl;
			end else begin
				lnl = (rl * (256 - link) + det * link) >> 8;
				lnr = (rr * (256 - link) + det * link) >> 8;
			end
			env_l = smooth(curve_of(lnl), env_l);
			env_r = smooth(curve_of(lnr), env_r);
			fb_l = scale(l, lin_gain(env_l));
			fb_r = mono ? 0 : scale(r, lin_gain(env_r));
			w.left = 24'(mix(fb_l, l));
			w.right = mono ? 24'd0 : 24'(mix(fb_r, r));
			w.reduction = 16'((env_l > env_r ? env_l : env_r) >> 16);
			pending.push_back(w);
		endfunction

		function void check(logic [63:0] d);
			gained_word_t w;
			if (pending.size() == 0) begin
				$display("%0t: unexpected output word %h", $time, d);
				errors++;
				return;
			end
			w = pending.pop_front();
			if (d[23:0] !== w.left) begin
				$display("%0t: left_out expected %h actual %h", $time, w.left, d[23:0]);
				errors++;
			end
			if (d[47:24] !== w.right) begin
				$display("%0t: right_out expected %h actual %h", $time, w.right, d[47:24]);
				errors++;
			end
			if (d[63:48] !== w.reduction) begin
				$display("%0t: reduction_db expected %h actual %h", $time, w.reduction,
					d[63:48]);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic s_tvalid, s_tready, m_tvalid, m_tready, cfg_valid, cfg_ready;
	logic [47:0] s_tdata;
	logic [63:0] m_tdata;
	logic [3:0] cfg_index;
	logic [16:0] cfg_data;
	gain_scoreboard sb;
	int cycles;
	int burst_left;
	int rx_count;
	bit rx_steady;

	stereo_soft_knee_compressor dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready) sb.check(m_tdata);
		rx_count <= rx_count + 1;
		if (rx_count % 700 == 0) rx_steady <= ($urandom_range(0, 2) == 0);
		if (rx_steady) m_tready <= 1'b1;
		else m_tready <= ($urandom_range(0, 3) != 0);
	end

	task automatic send_word(logic [23:0] l, logic [23:0] r);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata <= {r, l};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_input(l, r);
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 40);
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [3:0] idx, logic [16:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.write_reg(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_all(int thr, int slope, int knee, int atk, int rel, int wet,
			int dry, int ctrl);
		write_reg(REG_THRESHOLD, 17'(16'(thr)));
		write_reg(REG_SLOPE, 17'(slope));
		write_reg(REG_KNEE, 17'(knee));
		write_reg(REG_ATTACK, 17'(atk));
		write_reg(REG_RELEASE, 17'(rel));
		write_reg(REG_WET, 17'(wet));
		write_reg(REG_DRY, 17'(dry));
		write_reg(REG_CONTROL, 17'(ctrl));
	endtask

	function automatic logic [23:0] pick_sample();
		logic [23:0] v;
		case ($urandom_range(0, 5))
			0: v = 24'h7FFFFF;
			1: v = 24'h800000;
			2, 3: v = 24'($urandom);
			default: begin
				v = 24'($urandom >> $urandom_range(8, 31));
				if ($urandom_range(0, 1)) v = -v;
			end
		endcase
		return v;
	endfunction

	task automatic random_phase(int n);
		for (int i = 0; i < n; i++) send_word(pick_sample(), pick_sample());
		drain();
	endtask

	initial begin
		sb = new();
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cycles = 0;
		rx_count = 0;
		rx_steady = 1'b1;
		burst_left = 1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Defaults: silence, full scale of both signs, one LSB.
		send_word(24'h000000, 24'h000000);
		send_word(24'h7FFFFF, 24'h7FFFFF);
		send_word(24'h800000, 24'h800000);
		send_word(24'h7FFFFF, 24'h800000);
		send_word(24'h000001, 24'hFFFFFF);
		drain();

		// A write to an index past the last register must change nothing.
		write_reg(4'd9, 17'h1FFFF);
		write_reg(4'd15, 17'h00000);
		write_all(-1536, 65536, 0, 0, 65535, 65535, 65536, DET_AVG | (255 << 4));
		send_word(24'h400000, 24'h000100);
		send_word(24'h800000, 24'h000000);
		send_word(24'h000000, 24'h7FFFFF);
		drain();
		write_reg(REG_CONTROL, 17'(DET_POWER | 4 | (128 << 4)));
		send_word(24'h7FFFFF, 24'h800000);
		send_word(24'h123456, 24'hEDCBA9);
		send_word(24'h000000, 24'h000000);
		drain();
		write_reg(REG_CONTROL, 17'(3 | 8));
		write_reg(REG_KNEE, 17'd12288);
		write_reg(REG_THRESHOLD, 17'(16'(-24576)));
		send_word(24'h7FFFFF, 24'h7FFFFF);
		send_word(24'h000010, 24'h800000);
		send_word(24'h800000, 24'h123456);
		drain();
		write_all(0, 0, 12288, 65535, 0, 0, 0, 12'hFFF);
		send_word(24'h7FFFFF, 24'h7FFFFF);
		send_word(24'h800000, 24'h000001);
		drain();
		write_all(0, 65536, 0, 65535, 65535, 65535, 0, 0);
		send_word(24'h7FFFFF, 24'h800000);
		send_word(24'h000100, 24'hFFFF00);
		drain();

		for (int p = 0; p < 16; p++) begin
			if (p == 3)
				write_all(-24576, 65536, 12288, 0, 0, 65535, 65536, 4095);
			else if (p == 7)
				write_all(0, 0, 0, 0, 0, 0, 0, 0);
			else
				write_all(-$urandom_range(0, 24576), $urandom_range(0, 65536),
					$urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12288),
					$urandom_range(60000, 65535), $urandom_range(0, 65535),
					$urandom_range(0, 65535), $urandom_range(0, 65536),
					$urandom_range(0, 4095));
			random_phase(120);
		end

		repeat (250) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
